### design/gb3_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the 3x3 Gaussian blur stream block.
// No dependencies; every other file of the block imports this package.

package gb3_pkg;

  localparam int PixW         = 8;
  localparam int FrameWidthW  = 11;
  localparam int FrameHeightW = 13;
  localparam int WeightW      = 24;
  localparam int FracW        = 16;
  localparam int SumW         = 10;   // sum of four pixels
  localparam int CfgAddrW     = 3;
  localparam int CfgDataW     = 24;

  localparam int MaxWidthDef  = 1024;
  localparam int MaxHeightDef = 4096;
  localparam int OutqDepth    = 8;    // power of two

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] CfgFrameWidth   = 3'd0;
  localparam logic [CfgAddrW-1:0] CfgFrameHeight  = 3'd1;
  localparam logic [CfgAddrW-1:0] CfgCenterWeight = 3'd2;
  localparam logic [CfgAddrW-1:0] CfgEdgeWeight   = 3'd3;
  localparam logic [CfgAddrW-1:0] CfgCornerWeight = 3'd4;

  // Register values after reset.
  localparam logic [FrameWidthW-1:0]  RstFrameWidth   = 11'd640;
  localparam logic [FrameHeightW-1:0] RstFrameHeight  = 13'd480;
  localparam logic [WeightW-1:0]      RstCenterWeight = 24'd3412155;
  localparam logic [WeightW-1:0]      RstEdgeWeight   = 24'd2069580;
  localparam logic [WeightW-1:0]      RstCornerWeight = 24'd1255110;

  typedef struct packed {
    logic [WeightW-1:0] center_w;
    logic [WeightW-1:0] side_w;
    logic [WeightW-1:0] corner_w;
  } gb3_weights_t;

  // Border-corrected neighborhood of one output pixel.
  typedef struct packed {
    logic [PixW-1:0] center;
    logic [SumW-1:0] sides;
    logic [SumW-1:0] corners;
    logic            last;
  } gb3_taps_t;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            last;
  } gb3_result_t;

endpackage

### design/gb3_linebuf.sv
`timescale 1ns / 1ps
// Line buffer memory: upper and middle row sample per column, one read and
// one write port, registered read with write-to-read forwarding. Uses gb3_pkg.

module gb3_linebuf
  import gb3_pkg::*;
#(
  parameter int Depth = MaxWidthDef,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [AddrW-1:0]    rd_addr_i,
  output logic [2*PixW-1:0]   rd_data_o,   // {middle, upper}
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  logic [2*PixW-1:0]   wr_data_i
);

  logic [2*PixW-1:0] mem_q [Depth];
  logic [2*PixW-1:0] rd_q;
  logic [2*PixW-1:0] fwd_data_q;
  logic              fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q       <= mem_q[rd_addr_i];
    fwd_data_q <= wr_data_i;
  end

  // A read of the entry written in the same cycle returns the old word, so
  // the new word is taken from the bypass register instead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

### design/gb3_posdiv.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle, used to rebuild
// the output row and column after a configuration write. Uses gb3_pkg.

module gb3_posdiv
  import gb3_pkg::*;
#(
  parameter int DW = 23,
  parameter int VW = FrameWidthW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o
);

  localparam int CntW = $clog2(DW + 1);

  logic [DW-1:0]   quo_q;
  logic [VW-1:0]   rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [VW:0]     trial;
  logic [VW:0]     diff;
  logic            fits;

  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    diff  = trial - {1'b0, divisor_i};
    fits  = trial >= {1'b0, divisor_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        quo_q  <= dividend_i;
        rem_q  <= '0;
        cnt_q  <= CntW'(DW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        quo_q <= {quo_q[DW-2:0], fits};
        rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q || done_q;
  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

### design/gb3_mac.sv
`timescale 1ns / 1ps
// Weighted sum of the neighborhood: three parallel multiplies, a sum, the
// Q.16 truncation and saturation to one byte. Uses gb3_pkg.

module gb3_mac
  import gb3_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  gb3_taps_t    taps_i,
  input  gb3_weights_t weights_i,
  output logic         valid_o,
  output gb3_result_t  res_o,
  output logic [1:0]   inflight_o
);

  localparam int ProdCW = WeightW + PixW;
  localparam int ProdSW = WeightW + SumW;
  localparam int AccW   = ProdSW + 2;

  logic              a_valid_q;
  gb3_taps_t         a_taps_q;
  logic              b_valid_q;
  logic              b_last_q;
  logic [ProdCW-1:0] prod_c_q;
  logic [ProdSW-1:0] prod_s_q;
  logic [ProdSW-1:0] prod_k_q;
  logic [AccW-1:0]   acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_taps_q <= taps_i;
    prod_c_q <= ProdCW'(weights_i.center_w) * ProdCW'(a_taps_q.center);
    prod_s_q <= ProdSW'(weights_i.side_w) * ProdSW'(a_taps_q.sides);
    prod_k_q <= ProdSW'(weights_i.corner_w) * ProdSW'(a_taps_q.corners);
    b_last_q <= a_taps_q.last;
  end

  always_comb begin
    acc = AccW'(prod_c_q) + AccW'(prod_s_q) + AccW'(prod_k_q);
    res_o.last = b_last_q;
    if (|acc[AccW-1:FracW+PixW]) begin
      res_o.pixel = '1;
    end else begin
      res_o.pixel = acc[FracW+PixW-1:FracW];
    end
  end

  assign valid_o    = b_valid_q;
  assign inflight_o = {1'b0, a_valid_q} + {1'b0, b_valid_q};

endmodule

### design/gb3_outq.sv
`timescale 1ns / 1ps
// Result queue in front of the output stream; it parts the two sides so that
// a waiting result does not hold up the input. Uses gb3_pkg.

module gb3_outq
  import gb3_pkg::*;
#(
  localparam int PtrW = $clog2(OutqDepth),
  localparam int CntW = $clog2(OutqDepth + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gb3_result_t     push_data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output gb3_result_t     data_o,
  output logic [CntW-1:0] count_o
);

  gb3_result_t     slot_q [OutqDepth];
  logic [PtrW-1:0] head_q;
  logic [PtrW-1:0] tail_q;
  logic [CntW-1:0] count_q;
  logic            pop;

  assign valid_o = count_q != '0;
  assign pop     = valid_o && ready_i;
  assign data_o  = slot_q[head_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[tail_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        tail_q <= tail_q + 1'b1;
      end
      if (pop) begin
        head_q <= head_q + 1'b1;
      end
      count_q <= count_q + CntW'(push_i) - CntW'(pop);
    end
  end

endmodule

### design/gaussian_blur_3x3_stream.sv
`timescale 1ns / 1ps
// Top level of the streaming 3x3 Gaussian blur with replicated borders.
// Depends on gb3_pkg, gb3_linebuf, gb3_posdiv, gb3_mac and gb3_outq.

// The block takes one request per clock while tready is high, a pixel or a
// drain tick, and emits the blurred pixel of the sample that arrived
// frame_width+1 requests earlier; after the last pixel of a frame,
// frame_width+1 drain ticks flush the rest, and the final result carries
// tlast. A drain tick that comes before all pixels of the frame is accepted
// and dropped; a pixel after them counts as a drain tick. Sustained rate is
// one request per cycle while tready is high, set by the single line-buffer
// memory, which is read and written once per request (a read of the entry
// written in the same cycle is forwarded). A result passes the line-buffer
// read, the neighborhood registers, the three multipliers and the sum into
// the output queue before it can leave. The queue holds eight results;
// tready falls when queued and in-flight results fill it. After reset, and
// from a configuration write on, tready stays low while a bit-serial divider
// rebuilds the output row and column from the live frame width. The line
// buffers are not cleared: the first two rows of a frame are written before
// they are read. The user must write configuration only while no result is
// pending; the block itself does not enforce it.

module gaussian_blur_3x3_stream
  import gb3_pkg::*;
#(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Input stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [PixW-1:0]     s_axis_tdata,   // [7:0] pixel_in
  input  logic [0:0]          s_axis_tuser,   // [0] func: 0 pixel, 1 drain tick
  // Output stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [PixW-1:0]     m_axis_tdata,   // [7:0] blurred_pixel
  output logic                m_axis_tlast    // frame_last
);

  localparam int ColW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int HW      = $clog2(MAX_HEIGHT + 1);
  localparam int PixCntW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int ItemW   = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
  localparam int QCntW   = $clog2(OutqDepth + 1);

  // Per-request control carried from acceptance to the line-buffer stage.
  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            phase;   // pixel phase: the sample is written
    logic            prod;    // request yields a result
    logic            last;
    logic            top;
    logic            bot;
    logic            left;
    logic            right;
  } ctl_t;

  // Configuration registers.
  logic [FrameWidthW-1:0]  cfg_fw_q;
  logic [FrameHeightW-1:0] cfg_fh_q;
  gb3_weights_t            weights_q;
  logic                    cfg_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_fw_q           <= RstFrameWidth;
      cfg_fh_q           <= RstFrameHeight;
      weights_q.center_w <= RstCenterWeight;
      weights_q.side_w   <= RstEdgeWeight;
      weights_q.corner_w <= RstCornerWeight;
      cfg_pend_q         <= 1'b1;
    end else begin
      cfg_pend_q <= cfg_we_i;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CfgFrameWidth:   cfg_fw_q           <= cfg_data_i[FrameWidthW-1:0];
          CfgFrameHeight:  cfg_fh_q           <= cfg_data_i[FrameHeightW-1:0];
          CfgCenterWeight: weights_q.center_w <= cfg_data_i[WeightW-1:0];
          CfgEdgeWeight:   weights_q.side_w   <= cfg_data_i[WeightW-1:0];
          CfgCornerWeight: weights_q.corner_w <= cfg_data_i[WeightW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Live frame size: zero acts as one, anything above the maximum as the
  // maximum.
  logic [WW-1:0] width_live;
  logic [HW-1:0] height_live;

  always_comb begin
    if (cfg_fw_q == '0) begin
      width_live = WW'(1);
    end else if (32'(cfg_fw_q) > 32'(MAX_WIDTH)) begin
      width_live = WW'(MAX_WIDTH);
    end else begin
      width_live = WW'(cfg_fw_q);
    end
    if (cfg_fh_q == '0) begin
      height_live = HW'(1);
    end else if (32'(cfg_fh_q) > 32'(MAX_HEIGHT)) begin
      height_live = HW'(MAX_HEIGHT);
    end else begin
      height_live = HW'(cfg_fh_q);
    end
  end

  // Frame bounds, settled while the block is busy after a write.
  logic [PixCntW-1:0] pixels_q;
  logic [ItemW-1:0]   lag_q;
  logic [ItemW-1:0]   end_q;

  always_ff @(posedge clk_i) begin
    pixels_q <= PixCntW'(width_live) * PixCntW'(height_live);
    lag_q    <= ItemW'(width_live) + ItemW'(1);
    end_q    <= ItemW'(pixels_q) + ItemW'(width_live);
  end

  // Position counters: input column, request count of the frame, and the
  // row and column of the next output pixel.
  logic [ColW-1:0]  col_q, col_d;
  logic [ItemW-1:0] items_q, items_d;
  logic [ColW-1:0]  ocol_q, ocol_d;
  logic [ItemW-1:0] orow_q, orow_d;

  // Output position rebuild after a configuration write.
  logic [ItemW-1:0] lag_live;
  logic [ItemW-1:0] div_dividend;
  logic             div_busy;
  logic             div_done;
  logic [ItemW-1:0] div_quot;
  logic [WW-1:0]    div_rem;

  assign lag_live     = ItemW'(width_live) + ItemW'(1);
  assign div_dividend = (items_q >= lag_live) ? (items_q - lag_live) : '0;

  gb3_posdiv #(
    .DW (ItemW),
    .VW (WW)
  ) u_posdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cfg_pend_q),
    .dividend_i (div_dividend),
    .divisor_i  (width_live),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Input handshake and per-request decisions.
  logic              s1_valid_q;
  ctl_t              s1_ctl_q;
  logic [ColW-1:0]   s1_col_q;
  logic [1:0]        mac_inflight;
  logic [QCntW-1:0]  outq_count;
  logic              busy;
  logic              room;
  logic              accept;
  logic              phase;
  logic              take;
  logic              prod;
  logic              fend;
  logic              edge_top;
  logic              edge_bot;
  logic              edge_left;
  logic              edge_right;

  assign busy = cfg_we_i || cfg_pend_q || div_busy;
  assign room = (32'(outq_count) + 32'(mac_inflight) + 32'(s1_valid_q && s1_ctl_q.prod))
                < 32'(OutqDepth);
  assign s_axis_tready = !busy && room;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign phase      = items_q < ItemW'(pixels_q);
  assign take       = accept && !(s_axis_tuser[0] && phase);
  assign prod       = (items_q >= lag_q) && (items_q <= end_q);
  assign fend       = items_q >= end_q;
  assign edge_top   = orow_q == '0;
  assign edge_bot   = (32'(orow_q) + 32'd1) >= 32'(height_live);
  assign edge_left  = ocol_q == '0;
  assign edge_right = (32'(ocol_q) + 32'd1) >= 32'(width_live);

  always_comb begin
    col_d   = col_q;
    items_d = items_q;
    ocol_d  = ocol_q;
    orow_d  = orow_q;
    if (div_done) begin
      ocol_d = ColW'(div_rem);
      orow_d = div_quot;
    end
    if (take) begin
      if ((32'(col_q) + 32'd1) >= 32'(width_live)) begin
        col_d = '0;
      end else begin
        col_d = col_q + 1'b1;
      end
      items_d = items_q + 1'b1;
      if (prod) begin
        if (edge_right) begin
          ocol_d = '0;
          orow_d = orow_q + 1'b1;
        end else begin
          ocol_d = ocol_q + 1'b1;
        end
      end
      // The request that completes the frame restarts every counter.
      if (fend) begin
        col_d   = '0;
        items_d = '0;
        ocol_d  = '0;
        orow_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      items_q    <= '0;
      ocol_q     <= '0;
      orow_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      items_q    <= items_d;
      ocol_q     <= ocol_d;
      orow_q     <= orow_d;
      s1_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_col_q       <= col_q;
    s1_ctl_q.pixel <= s_axis_tdata;
    s1_ctl_q.phase <= phase;
    s1_ctl_q.prod  <= prod;
    s1_ctl_q.last  <= prod && fend;
    s1_ctl_q.top   <= edge_top;
    s1_ctl_q.bot   <= edge_bot;
    s1_ctl_q.left  <= edge_left;
    s1_ctl_q.right <= edge_right;
  end

  // Line buffers: read at acceptance, written back in the next cycle with the
  // middle sample moved up and the new sample in the middle.
  logic [2*PixW-1:0] lb_rd_data;
  logic [PixW-1:0]   fresh [3];

  always_comb begin
    fresh[0] = lb_rd_data[PixW-1:0];
    fresh[1] = lb_rd_data[2*PixW-1:PixW];
    fresh[2] = s1_ctl_q.phase ? s1_ctl_q.pixel : lb_rd_data[2*PixW-1:PixW];
  end

  gb3_linebuf #(
    .Depth (MAX_WIDTH)
  ) u_linebuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (col_q),
    .rd_data_o (lb_rd_data),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({fresh[2], fresh[1]})
  );

  // Window of the last three columns, three rows each; entry col*3+row,
  // column 0 oldest, row 0 top.
  logic [PixW-1:0] win_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_valid_q) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= win_q[i+3];
      end
      for (int r = 0; r < 3; r++) begin
        win_q[6+r] <= fresh[r];
      end
    end
  end

  // Neighborhood with replicated borders: the centre column is the newest
  // window column, the left and right columns fall back on it at the row
  // ends, and the top and bottom samples fall back on the middle row.
  logic [PixW-1:0] lraw [3];
  logic [PixW-1:0] craw [3];
  logic [PixW-1:0] rraw [3];
  logic [PixW-1:0] lcol [3];
  logic [PixW-1:0] ccol [3];
  logic [PixW-1:0] rcol [3];
  gb3_taps_t       taps;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      craw[r] = win_q[6+r];
      lraw[r] = s1_ctl_q.left ? win_q[6+r] : win_q[3+r];
      rraw[r] = s1_ctl_q.right ? win_q[6+r] : fresh[r];
    end
    lcol[1] = lraw[1];
    ccol[1] = craw[1];
    rcol[1] = rraw[1];
    lcol[0] = s1_ctl_q.top ? lraw[1] : lraw[0];
    ccol[0] = s1_ctl_q.top ? craw[1] : craw[0];
    rcol[0] = s1_ctl_q.top ? rraw[1] : rraw[0];
    lcol[2] = s1_ctl_q.bot ? lraw[1] : lraw[2];
    ccol[2] = s1_ctl_q.bot ? craw[1] : craw[2];
    rcol[2] = s1_ctl_q.bot ? rraw[1] : rraw[2];
    taps.center  = ccol[1];
    taps.sides   = SumW'(ccol[0]) + SumW'(ccol[2]) + SumW'(lcol[1]) + SumW'(rcol[1]);
    taps.corners = SumW'(lcol[0]) + SumW'(lcol[2]) + SumW'(rcol[0]) + SumW'(rcol[2]);
    taps.last    = s1_ctl_q.last;
  end

  logic        mac_valid;
  gb3_result_t mac_res;
  gb3_result_t outq_data;

  gb3_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s1_valid_q && s1_ctl_q.prod),
    .taps_i     (taps),
    .weights_i  (weights_q),
    .valid_o    (mac_valid),
    .res_o      (mac_res),
    .inflight_o (mac_inflight)
  );

  gb3_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (mac_valid),
    .push_data_i (mac_res),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (outq_data),
    .count_o     (outq_count)
  );

  assign m_axis_tdata = outq_data.pixel;
  assign m_axis_tlast = outq_data.last;

endmodule

### bench/tb_gaussian_blur_3x3_stream.sv
`timescale 1ns / 1ps
// Self-checking bench for gaussian_blur_3x3_stream: random and directed frames,
// predicted pixel by pixel and compared on the output stream.
// Depends on gb3_pkg and the gaussian_blur_3x3_stream RTL.

module tb_gaussian_blur_3x3_stream;
  import gb3_pkg::*;

  // A no-progress stretch longer than this ends the run. The slowest legal
  // stretch is the long output hold plus the divider rebuild after a write.
  localparam int StallLimit = 5000;
  localparam int FrameItems = 80;   // minimum items per random idling phase

  // One column of the 3x3 window: rows two above, one above and current.
  typedef struct packed {
    bit [7:0] top;
    bit [7:0] mid;
    bit [7:0] bot;
  } pixel_col_t;

  // Shadow of the blur datapath plus the store of blurred pixels not yet seen.
  class blur_scoreboard;
    bit [FrameWidthW-1:0]  frame_width;
    bit [FrameHeightW-1:0] frame_height;
    bit [WeightW-1:0]      center_w;
    bit [WeightW-1:0]      side_w;
    bit [WeightW-1:0]      corner_w;
    bit [7:0]              upper_line [MaxWidthDef];
    bit [7:0]              middle_line [MaxWidthDef];
    pixel_col_t            win [3];  // 0 oldest, 2 newest
    int unsigned           column_count;
    int unsigned           items_seen;
    gb3_result_t           blurred_q [$];
    int unsigned           errors, n_pixels, n_drains, n_ignored, n_results, n_frames;

    function void reset_state();
      frame_width  = RstFrameWidth;
      frame_height = RstFrameHeight;
      center_w     = RstCenterWeight;
      side_w       = RstEdgeWeight;
      corner_w     = RstCornerWeight;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      column_count = 0;
      items_seen   = 0;
    endfunction

    function void write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
      case (addr)
        CfgFrameWidth:   frame_width  = data[FrameWidthW-1:0];
        CfgFrameHeight:  frame_height = data[FrameHeightW-1:0];
        CfgCenterWeight: center_w     = data[WeightW-1:0];
        CfgEdgeWeight:   side_w       = data[WeightW-1:0];
        CfgCornerWeight: corner_w     = data[WeightW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned live_width();
      if (frame_width == 0) return 1;
      if (frame_width > MaxWidthDef) return MaxWidthDef;
      return frame_width;
    endfunction

    function int unsigned live_height();
      if (frame_height == 0) return 1;
      if (frame_height > MaxHeightDef) return MaxHeightDef;
      return frame_height;
    endfunction

    // Border replication: outside rows take the value of the center row.
    function pixel_col_t replicate_rows(pixel_col_t c, bit top_edge, bit bottom_edge);
      pixel_col_t r;
      r = c;
      if (top_edge) r.top = c.mid;
      if (bottom_edge) r.bot = c.mid;
      return r;
    endfunction

    function int unsigned pending();
      return blurred_q.size();
    endfunction

    // Called for every accepted request; queues the blurred pixel it releases.
    function void note_request(bit drain, bit [7:0] pix);
      int unsigned w, h, pixels, t, col, o, orow, ocol;
      bit          pixel_phase, top_edge, bottom_edge;
      pixel_col_t  fresh, lc, cc, rc;
      bit [63:0]   sides, corners, acc;
      gb3_result_t res;
      w = live_width();
      h = live_height();
      pixels = w * h;
      t = items_seen;
      col = column_count;
      pixel_phase = t < pixels;
      // A drain tick while pixels are still due changes nothing.
      if (drain && pixel_phase) begin
        n_ignored++;
        return;
      end
      if (drain) n_drains++;
      else n_pixels++;
      if (col >= MaxWidthDef) col = 0;
      // Past the last pixel, the bottom row repeats the middle one.
      fresh.top = upper_line[col];
      fresh.mid = middle_line[col];
      fresh.bot = pixel_phase ? pix : fresh.mid;
      upper_line[col]  = fresh.mid;
      middle_line[col] = fresh.bot;
      if (t >= w + 1 && t - w - 1 < pixels) begin
        o = t - w - 1;
        orow = o / w;
        ocol = o % w;
        top_edge = orow == 0;
        bottom_edge = orow + 1 >= h;
        cc = replicate_rows(win[2], top_edge, bottom_edge);
        lc = replicate_rows((ocol == 0) ? win[2] : win[1], top_edge, bottom_edge);
        rc = replicate_rows((ocol + 1 >= w) ? win[2] : fresh, top_edge, bottom_edge);
        sides = 64'(cc.top) + 64'(cc.bot) + 64'(lc.mid) + 64'(rc.mid);
        corners = 64'(lc.top) + 64'(lc.bot) + 64'(rc.top) + 64'(rc.bot);
        acc = (64'(center_w) * 64'(cc.mid) + 64'(side_w) * sides
               + 64'(corner_w) * corners) >> FracW;
        res.pixel = (acc > 255) ? 8'hFF : acc[7:0];
        res.last = t >= pixels + w;
        blurred_q.push_back(res);
      end
      win[0] = win[1];
      win[1] = win[2];
      win[2] = fresh;
      column_count = (col + 1 >= w) ? 0 : col + 1;
      items_seen = t + 1;
      // The request that yields the final pixel also starts a new frame.
      if (t >= pixels + w) begin
        column_count = 0;
        items_seen = 0;
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_result(logic [7:0] pix, logic last);
      gb3_result_t want;
      n_results++;
      if (last === 1'b1) n_frames++;
      if (blurred_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result pixel=%0d last=%b", pix, last));
        return;
      end
      want = blurred_q.pop_front();
      if (pix !== want.pixel)
        report_mismatch($sformatf("result %0d: pixel %0d, want %0d",
                                  n_results, pix, want.pixel));
      if (last !== want.last)
        report_mismatch($sformatf("result %0d: tlast %b, want %b",
                                  n_results, last, want.last));
    endtask

    task check_drained();
      if (blurred_q.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", blurred_q.size()));
    endtask
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i    = CfgFrameWidth;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [PixW-1:0]     s_axis_tdata  = '0;   // [7:0] pixel_in
  logic [0:0]          s_axis_tuser  = '0;   // [0] func: 0 pixel, 1 drain tick
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [PixW-1:0]     m_axis_tdata;         // [7:0] blurred_pixel
  logic                m_axis_tlast;         // frame_last

  blur_scoreboard sb;
  int tx_idle_pct  = 0;   // chance that the sender skips a cycle
  int rx_stall_pct = 0;   // chance that the receiver holds tready low
  int rx_hold_left = 0;   // cycles left in a forced output hold
  int stall_cycles = 0;
  int unsigned frame_req_count = 0;

  gaussian_blur_3x3_stream dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver side: tready moves at the falling edge. A forced hold is counted
  // down here so that the sender keeps pushing while the block fills up.
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Results are taken at the rising edge, where the handshake is decided.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  // Watchdog: any accepted request or result restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("Watchdog: no progress for %0d cycles", StallLimit);
        $display("tb_gaussian_blur_3x3_stream failed");
        $finish;
      end
    end
  end

  // Offers one request and returns at the edge that accepts it. Random idle
  // cycles go in front; at most one update of tvalid happens per falling edge.
  task send_item(bit drain, bit [7:0] pix);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= drain;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(drain, pix);
  endtask

  // Drops the input and waits until every queued blurred pixel has come out.
  task wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    sb.write_reg(addr, data);
  endtask

  // Reconfigures between frames. Ignored drain ticks leave nothing queued, so
  // the task waits on past the last result to let the pipeline go empty.
  task set_frame(int unsigned w, int unsigned h, bit [23:0] cw, bit [23:0] ew,
                 bit [23:0] kw);
    wait_drained();
    repeat (8) @(negedge clk_i);
    write_reg(CfgFrameWidth, CfgDataW'(w));
    write_reg(CfgFrameHeight, CfgDataW'(h));
    write_reg(CfgCenterWeight, cw);
    write_reg(CfgEdgeWeight, ew);
    write_reg(CfgCornerWeight, kw);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function bit [7:0] pick_pixel();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One frame: all pixels, then width+1 drain ticks. Noise adds early drain
  // ticks that the block must drop, and turns some drain ticks into late
  // pixels whose value is ignored.
  task run_frame(int noise_pct, bit pause_mid);
    int unsigned w, pixels, i;
    w = sb.live_width();
    pixels = w * sb.live_height();
    for (i = 0; i < pixels; i++) begin
      if ($urandom_range(99) < noise_pct) send_item(1'b1, pick_pixel());
      if (pause_mid && i == pixels / 2) wait_drained();
      send_item(1'b0, pick_pixel());
    end
    for (i = 0; i <= w; i++)
      send_item(($urandom_range(99) < noise_pct) ? 1'b0 : 1'b1, pick_pixel());
    frame_req_count += pixels + w + 1;
  endtask

  task random_frame(bit pause_mid);
    int unsigned w, h;
    bit [23:0]   cw, ew, kw;
    w = ($urandom_range(4) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
    h = $urandom_range(1, 5);
    case ($urandom_range(3))
      0: begin
        cw = RstCenterWeight;
        ew = RstEdgeWeight;
        kw = RstCornerWeight;
      end
      1: begin
        cw = 24'($urandom_range(24'h7FFFFF));
        ew = 24'($urandom_range(24'h3FFFFF));
        kw = 24'($urandom_range(24'h3FFFFF));
      end
      2: begin
        cw = 24'($urandom_range(24'hFFFFFF));
        ew = 24'($urandom_range(24'hFFFFFF));
        kw = 24'($urandom_range(24'hFFFFFF));
      end
      default: begin
        cw = $urandom_range(1) ? 24'hFFFFFF : 24'h0;
        ew = $urandom_range(1) ? 24'hFFFFFF : 24'h0;
        kw = $urandom_range(1) ? 24'hFFFFFF : 24'h0;
      end
    endcase
    set_frame(w, h, cw, ew, kw);
    run_frame(8, pause_mid);
  endtask

  initial begin
    int unsigned phase_start;
    sb = new();
    sb.reset_state();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: 3x2 frame of black and white pixels with the reset weights.
    // An early drain tick is dropped, and a late pixel acts as a drain tick.
    set_frame(3, 2, RstCenterWeight, RstEdgeWeight, RstCornerWeight);
    send_item(1'b1, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'h7F);
    send_item(1'b1, 8'h00);
    send_item(1'b1, 8'h00);
    // Full-scale weights saturate every result.
    set_frame(2, 2, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h01);
    send_item(1'b0, 8'hC8);
    send_item(1'b0, 8'h00);
    send_item(1'b1, 8'h00);
    send_item(1'b1, 8'h00);
    send_item(1'b1, 8'h00);
    // Zero sizes act as a 1x1 frame; zero weights give black.
    set_frame(0, 0, 24'h0, 24'h0, 24'h0);
    send_item(1'b0, 8'hFF);
    send_item(1'b1, 8'h00);
    send_item(1'b1, 8'hFF);

    // Back pressure: the output is held long enough for the block to fill
    // its queue and stall the input while requests keep coming.
    set_frame(4, 8, RstCenterWeight, RstEdgeWeight, RstCornerWeight);
    @(posedge clk_i);
    rx_hold_left = 300;
    run_frame(0, 1'b0);

    // Random frames under four idling profiles; the first frame of the mixed
    // profile pauses mid-frame until every queued result has come out.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 88; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 88; end
        default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
      endcase
      phase_start = frame_req_count;
      while (frame_req_count - phase_start < FrameItems)
        random_frame(phase == 3 && frame_req_count == phase_start);
    end

    tx_idle_pct = 0;
    rx_stall_pct = 0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    sb.check_drained();

    $display("Covered %0d frames: %0d pixels, %0d drain ticks, %0d dropped ticks;",
             sb.n_frames, sb.n_pixels, sb.n_drains, sb.n_ignored);
    $display("%0d blurred pixels checked, %0d mismatches.", sb.n_results, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_gaussian_blur_3x3_stream passed");
    end else begin
      $display("tb_gaussian_blur_3x3_stream failed");
    end
    $finish;
  end

endmodule

### sim.f
design/gb3_pkg.sv
design/gb3_linebuf.sv
design/gb3_posdiv.sv
design/gb3_mac.sv
design/gb3_outq.sv
design/gaussian_blur_3x3_stream.sv
bench/tb_gaussian_blur_3x3_stream.sv
